// ----- rtl/core/refslot_pkg.sv -----
`timescale 1ns / 1ps
// Package for the reference-counted slot table: field widths, result codes,
// request codes and the controller/datapath command and status structs.
// No dependencies.
package refslot_pkg;

   localparam int SLOTS_DEFAULT    = 16;
   localparam int KEY_BITS_DEFAULT = 32;

   localparam int NAME_KEY_BITS   = 32;
   localparam int STATUS_BITS     = 3;
   localparam int SLOT_INDEX_BITS = 4;
   localparam int REF_COUNT_BITS  = 16;

   localparam logic [REF_COUNT_BITS-1:0] REFS_MAX = '1;

   // request codes
   localparam logic REQ_ACQUIRE = 1'b0;
   localparam logic REQ_RELEASE = 1'b1;

   // result status codes
   localparam logic [STATUS_BITS-1:0] ST_HIT     = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_NEW     = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_FULL    = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_KEPT    = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_FREED   = 3'd4;
   localparam logic [STATUS_BITS-1:0] ST_MISSING = 3'd5;

   typedef struct packed {
      logic load;    // capture the incoming transaction, restart the scan
      logic scan;    // step the slot scan
      logic commit;  // apply the update and post the result
   } dp_cmd_type;

   typedef struct packed {
      logic hit;       // key match on the slot compared this cycle
      logic done;      // last slot compared, no match
      logic out_free;  // result register can take a new result
   } dp_sts_type;

endpackage

// ----- rtl/core/refslot_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and response sides.
// Depends on refslot_pkg.
interface refslot_req_if import refslot_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     req_type;
   logic [NAME_KEY_BITS-1:0] name_key;

   modport source (output valid, output req_type, output name_key, input ready);
   modport sink   (input valid, input req_type, input name_key, output ready);
endinterface

interface refslot_rsp_if import refslot_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [STATUS_BITS-1:0]     status;
   logic [SLOT_INDEX_BITS-1:0] slot_index;
   logic [REF_COUNT_BITS-1:0]  ref_count;

   modport source (output valid, output status, output slot_index, output ref_count,
                   input ready);
   modport sink   (input valid, input status, input slot_index, input ref_count,
                   output ready);
endinterface

// ----- rtl/core/refslot_ctrl.sv -----
`timescale 1ns / 1ps
// Controller for the slot table: accept, scan and update sequencing.
// Depends on refslot_pkg.
module refslot_ctrl import refslot_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_UPDATE = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.hit || sts.done) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            // hold until the result register is free
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/core/refslot_dp.sv -----
`timescale 1ns / 1ps
// Datapath for the slot table: key and count memories, allocation bits,
// scan compare, update arithmetic and the result register.
// Depends on refslot_pkg and refslot_if.
module refslot_dp import refslot_pkg::*; #(
   parameter int SLOTS    = SLOTS_DEFAULT,
   parameter int KEY_BITS = KEY_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dp_cmd_type               cmd,
   output dp_sts_type               sts,
   input  logic                     req_type,
   input  logic [NAME_KEY_BITS-1:0] name_key,
   refslot_rsp_if.source            rsp_chan
);

   localparam int IDX_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_BITS = $clog2(SLOTS + 1);

   logic [KEY_BITS-1:0] key_in;

   generate
      if (KEY_BITS <= NAME_KEY_BITS) begin : g_key_trunc
         assign key_in = name_key[KEY_BITS-1:0];
      end else begin : g_key_ext
         assign key_in = {{(KEY_BITS-NAME_KEY_BITS){1'b0}}, name_key};
      end
   endgenerate

   // slot storage; keys and counts are only meaningful for allocated slots
   logic [KEY_BITS-1:0]       slot_key_mem  [SLOTS];
   logic [REF_COUNT_BITS-1:0] slot_refs_mem [SLOTS];
   logic [SLOTS-1:0]          alloc_ff, alloc_in;

   logic                      req_type_ff, req_type_in;
   logic [KEY_BITS-1:0]       key_ff, key_in_r;
   logic [CNT_BITS-1:0]       rd_addr_ff, rd_addr_in;
   logic                      cmp_vld_ff, cmp_vld_in;
   logic [IDX_BITS-1:0]       cmp_idx_ff, cmp_idx_in;
   logic [KEY_BITS-1:0]       key_rd_ff;
   logic [REF_COUNT_BITS-1:0] refs_rd_ff;
   logic                      hit_ff, hit_in;
   logic [IDX_BITS-1:0]       hit_idx_ff, hit_idx_in;
   logic [REF_COUNT_BITS-1:0] hit_refs_ff, hit_refs_in;
   logic                      free_ff, free_in;
   logic [IDX_BITS-1:0]       free_idx_ff, free_idx_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0]     rsp_status_ff, rsp_status_in;
   logic [SLOT_INDEX_BITS-1:0] rsp_index_ff, rsp_index_in;
   logic [REF_COUNT_BITS-1:0]  rsp_count_ff, rsp_count_in;

   logic                      rd_en;
   logic [IDX_BITS-1:0]       rd_idx;
   logic                      match;
   logic                      last;
   logic                      free_here;

   logic                      wr_key_en;
   logic                      wr_refs_en;
   logic                      set_alloc;
   logic                      clr_alloc;
   logic                      touched;
   logic [IDX_BITS-1:0]       wr_idx;
   logic [REF_COUNT_BITS-1:0] wr_refs;
   logic [STATUS_BITS-1:0]    upd_status;
   logic [REF_COUNT_BITS-1:0] upd_count;

   assign rd_en     = cmd.scan && (rd_addr_ff < CNT_BITS'(SLOTS));
   assign rd_idx    = rd_addr_ff[IDX_BITS-1:0];
   assign match     = cmp_vld_ff && alloc_ff[cmp_idx_ff] && (key_rd_ff == key_ff);
   assign last      = cmp_vld_ff && (cmp_idx_ff == IDX_BITS'(SLOTS - 1));
   assign free_here = cmp_vld_ff && !alloc_ff[cmp_idx_ff];

   assign sts.hit      = match;
   assign sts.done     = last && !match;
   assign sts.out_free = !rsp_valid_ff || rsp_chan.ready;

   // update decision from the scan results
   always_comb begin
      wr_key_en  = 1'b0;
      wr_refs_en = 1'b0;
      set_alloc  = 1'b0;
      clr_alloc  = 1'b0;
      touched    = 1'b0;
      wr_idx     = hit_idx_ff;
      wr_refs    = '0;
      upd_status = ST_MISSING;
      upd_count  = '0;
      if (req_type_ff == REQ_ACQUIRE) begin
         priority if (hit_ff) begin
            touched    = 1'b1;
            wr_refs_en = 1'b1;
            wr_refs    = (hit_refs_ff == REFS_MAX) ? hit_refs_ff
                                                   : hit_refs_ff + REF_COUNT_BITS'(1);
            upd_status = ST_HIT;
            upd_count  = wr_refs;
         end else if (free_ff) begin
            touched    = 1'b1;
            wr_idx     = free_idx_ff;
            wr_key_en  = 1'b1;
            wr_refs_en = 1'b1;
            set_alloc  = 1'b1;
            wr_refs    = REF_COUNT_BITS'(1);
            upd_status = ST_NEW;
            upd_count  = wr_refs;
         end else begin
            upd_status = ST_FULL;
         end
      end else begin
         if (hit_ff) begin
            touched = 1'b1;
            if (hit_refs_ff <= REF_COUNT_BITS'(1)) begin
               clr_alloc  = 1'b1;
               upd_status = ST_FREED;
            end else begin
               wr_refs_en = 1'b1;
               wr_refs    = hit_refs_ff - REF_COUNT_BITS'(1);
               upd_status = ST_KEPT;
               upd_count  = wr_refs;
            end
         end else begin
            upd_status = ST_MISSING;
         end
      end
   end

   always_comb begin
      req_type_in = req_type_ff;
      key_in_r    = key_ff;
      rd_addr_in  = rd_addr_ff;
      cmp_vld_in  = 1'b0;
      cmp_idx_in  = rd_idx;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_refs_in = hit_refs_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      alloc_in    = alloc_ff;

      if (cmd.load) begin
         req_type_in = req_type;
         key_in_r    = key_in;
         rd_addr_in  = '0;
         hit_in      = 1'b0;
         free_in     = 1'b0;
      end

      if (cmd.scan) begin
         cmp_vld_in = rd_en;
         if (rd_en) begin
            rd_addr_in = rd_addr_ff + CNT_BITS'(1);
         end
         if (match) begin
            hit_in      = 1'b1;
            hit_idx_in  = cmp_idx_ff;
            hit_refs_in = refs_rd_ff;
         end
         // lowest free slot seen so far
         if (free_here && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = cmp_idx_ff;
         end
      end

      if (cmd.commit) begin
         if (set_alloc) begin
            alloc_in[wr_idx] = 1'b1;
         end
         if (clr_alloc) begin
            alloc_in[wr_idx] = 1'b0;
         end
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_count_in  = rsp_count_ff;
      if (cmd.commit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = upd_status;
         rsp_index_in  = touched ? SLOT_INDEX_BITS'(wr_idx) : '0;
         rsp_count_in  = upd_count;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         alloc_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         rd_addr_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         alloc_ff     <= alloc_in;
         cmp_vld_ff   <= cmp_vld_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         rd_addr_ff   <= rd_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      req_type_ff   <= req_type_in;
      key_ff        <= key_in_r;
      cmp_idx_ff    <= cmp_idx_in;
      hit_idx_ff    <= hit_idx_in;
      hit_refs_ff   <= hit_refs_in;
      free_idx_ff   <= free_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // memories: one registered read port for the scan, one write port for the update
   always_ff @(posedge clock) begin
      if (rd_en) begin
         key_rd_ff  <= slot_key_mem[rd_idx];
         refs_rd_ff <= slot_refs_mem[rd_idx];
      end
      if (cmd.commit && wr_key_en) begin
         slot_key_mem[wr_idx] <= key_ff;
      end
      if (cmd.commit && wr_refs_en) begin
         slot_refs_mem[wr_idx] <= wr_refs;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.slot_index = rsp_index_ff;
   assign rsp_chan.ref_count  = rsp_count_ff;

endmodule

// ----- rtl/core/refcounted_named_slot_table_core.sv -----
`timescale 1ns / 1ps
// Reference-counted slot table. An acquire transaction returns the slot
// holding its key with the count raised by one (saturating at the maximum),
// or claims the lowest free slot with count 1, or reports a full table. A
// release transaction lowers the matching slot's count and frees it at zero,
// or reports the key as not found. One transaction is in work at a time:
// the slot memories are scanned one slot per cycle through a single read
// port, and the scan ends at the slot that holds the key or after the last
// slot when the key matches nothing. A finished result waits in an output
// register, and the next request is taken while it waits. Only the low
// KEY_BITS bits of name_key are compared and stored.
// Depends on refslot_pkg, refslot_if, refslot_ctrl and refslot_dp.
module refcounted_named_slot_table_core import refslot_pkg::*; #(
   parameter int SLOTS    = SLOTS_DEFAULT,
   parameter int KEY_BITS = KEY_BITS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   refslot_req_if.sink   req_chan,
   refslot_rsp_if.source rsp_chan
);

   dp_cmd_type dp_cmd;
   dp_sts_type dp_sts;
   logic       req_ready;

   assign req_chan.ready = req_ready;

   refslot_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .sts       (dp_sts),
      .cmd       (dp_cmd)
   );

   refslot_dp #(
      .SLOTS    (SLOTS),
      .KEY_BITS (KEY_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (dp_cmd),
      .sts      (dp_sts),
      .req_type (req_chan.req_type),
      .name_key (req_chan.name_key),
      .rsp_chan (rsp_chan)
   );

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request taken while a transaction is in work");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.commit |-> !(rsp_chan.valid && !rsp_chan.ready))
      else $error("pending result overwritten");

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({dp_cmd.load, dp_cmd.scan, dp_cmd.commit}))
      else $error("datapath commands overlap");

   a_untouched_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status == ST_FULL || rsp_chan.status == ST_MISSING))
      |-> (rsp_chan.slot_index == '0 && rsp_chan.ref_count == '0))
      else $error("nonzero slot fields on a result that touched no slot");
`endif

endmodule

// ----- tb/tb_refcounted_named_slot_table_core.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for refcounted_named_slot_table_core: directed and random
// acquire/release traffic checked against a slot-table predictor.
// Depends on refslot_pkg, refslot_if and the core RTL.
module tb_refcounted_named_slot_table_core;
   import refslot_pkg::*;

   localparam int N_SLOTS    = SLOTS_DEFAULT;
   localparam int POOL_SIZE  = 20;
   localparam int STALL_PCT  = 29;
   localparam int WDOG_LIMIT = 4000;
   localparam int DRAIN_WAIT = 25;

   typedef struct packed {
      logic [STATUS_BITS-1:0]     status;
      logic [SLOT_INDEX_BITS-1:0] slot_index;
      logic [REF_COUNT_BITS-1:0]  ref_count;
   } slot_result_type;

   logic clock;
   logic reset;

   refslot_req_if req_chan();
   refslot_rsp_if rsp_chan();

   refcounted_named_slot_table_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // predicted table contents
   logic                      tbl_busy  [N_SLOTS];
   logic [NAME_KEY_BITS-1:0]  tbl_key   [N_SLOTS];
   logic [REF_COUNT_BITS-1:0] tbl_count [N_SLOTS];

   slot_result_type          pending_results[$];
   logic [NAME_KEY_BITS-1:0] key_pool[POOL_SIZE];
   bit                       no_idle;
   int                       mismatches;
   int                       errors;
   int                       quiet_cycles;

   always #1 clock = ~clock;

   // Apply one request to the predicted table and return the expected response.
   function automatic slot_result_type table_update(logic op, logic [NAME_KEY_BITS-1:0] key);
      slot_result_type r;
      int hit_slot;
      int free_slot;
      r = '0;
      hit_slot = -1;
      free_slot = -1;
      for (int i = N_SLOTS - 1; i >= 0; i--) begin
         if (tbl_busy[i] && tbl_key[i] == key) hit_slot = i;
         if (!tbl_busy[i]) free_slot = i;
      end
      if (op == REQ_ACQUIRE) begin
         if (hit_slot >= 0) begin
            if (tbl_count[hit_slot] != REFS_MAX) tbl_count[hit_slot]++;
            r.status     = ST_HIT;
            r.slot_index = SLOT_INDEX_BITS'(hit_slot);
            r.ref_count  = tbl_count[hit_slot];
         end else if (free_slot >= 0) begin
            tbl_busy[free_slot]  = 1'b1;
            tbl_key[free_slot]   = key;
            tbl_count[free_slot] = REF_COUNT_BITS'(1);
            r.status     = ST_NEW;
            r.slot_index = SLOT_INDEX_BITS'(free_slot);
            r.ref_count  = REF_COUNT_BITS'(1);
         end else begin
            r.status = ST_FULL;
         end
      end else begin
         if (hit_slot >= 0) begin
            r.slot_index = SLOT_INDEX_BITS'(hit_slot);
            if (tbl_count[hit_slot] <= REF_COUNT_BITS'(1)) begin
               tbl_count[hit_slot] = '0;
               tbl_busy[hit_slot]  = 1'b0;
               r.status = ST_FREED;
            end else begin
               tbl_count[hit_slot]--;
               r.status    = ST_KEPT;
               r.ref_count = tbl_count[hit_slot];
            end
         end else begin
            r.status = ST_MISSING;
         end
      end
      return r;
   endfunction

   // Drive one request and hold it until the core takes it.
   task automatic send_request(logic op, logic [NAME_KEY_BITS-1:0] key);
      while (!no_idle && $urandom_range(99) < STALL_PCT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.req_type <= op;
      req_chan.name_key <= key;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      pending_results.push_back(table_update(op, key));
   endtask

   // Release every slot the predictor holds until the table is empty.
   task automatic release_all;
      logic [NAME_KEY_BITS-1:0] key;
      int                       refs;
      for (int i = 0; i < N_SLOTS; i++) begin
         if (tbl_busy[i]) begin
            key  = tbl_key[i];
            refs = int'(tbl_count[i]);
            repeat (refs) send_request(REQ_RELEASE, key);
         end
      end
   endtask

   task automatic test_hit_and_release;
      send_request(REQ_ACQUIRE, 32'h0000_0000);
      send_request(REQ_ACQUIRE, 32'hFFFF_FFFF);
      send_request(REQ_ACQUIRE, 32'h0000_0000);
      send_request(REQ_RELEASE, 32'h0000_0000);
      send_request(REQ_RELEASE, 32'h0000_0000);
      send_request(REQ_RELEASE, 32'h0000_0000);   // already freed: not found
      send_request(REQ_RELEASE, 32'hFFFF_FFFF);
   endtask

   task automatic test_fill_to_full;
      for (int i = 0; i < N_SLOTS; i++)
         send_request(REQ_ACQUIRE, 32'h0F0F_0000 + i);
      send_request(REQ_ACQUIRE, 32'hDEAD_BEEF);                // table full
      send_request(REQ_ACQUIRE, 32'h0F0F_0000 + N_SLOTS - 1);  // hit in last slot
      send_request(REQ_RELEASE, 32'h0F0F_0007);
      send_request(REQ_ACQUIRE, 32'hA5A5_5A5A);                // reuses the freed hole
      send_request(REQ_RELEASE, 32'h1234_5678);                // full scan, no match
      release_all();
   endtask

   // Alternating drain and fill blocks over a small key pool, with some stray keys.
   task automatic test_random_traffic(int n_blocks, int block_len);
      logic                     op;
      logic [NAME_KEY_BITS-1:0] key;
      int                       acq_pct;
      for (int b = 0; b < n_blocks; b++) begin
         acq_pct = (b % 2 == 0) ? 25 : 75;
         no_idle = (b == 3);
         for (int n = 0; n < block_len; n++) begin
            op = ($urandom_range(99) < acq_pct) ? REQ_ACQUIRE : REQ_RELEASE;
            if ($urandom_range(99) < 15)
               key = $urandom;
            else
               key = key_pool[$urandom_range(POOL_SIZE - 1)];
            send_request(op, key);
         end
      end
      no_idle = 0;
   endtask

   // Empty the table, then run one slot's count up and back down past zero.
   task automatic test_count_run;
      release_all();
      repeat (30) send_request(REQ_ACQUIRE, 32'h5A5A_0001);
      repeat (31) send_request(REQ_RELEASE, 32'h5A5A_0001);
   endtask

   // response side: random back-pressure
   always @(posedge clock)
      rsp_chan.ready <= no_idle || ($urandom_range(99) >= STALL_PCT);

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_results.size() == 0) begin
            errors++;
            $display("ERROR: response with no request outstanding: status=%0d slot=%0d",
                     rsp_chan.status, rsp_chan.slot_index);
         end else begin
            slot_result_type exp_r;
            slot_result_type got_r;
            exp_r = pending_results.pop_front();
            got_r = '{rsp_chan.status, rsp_chan.slot_index, rsp_chan.ref_count};
            if (got_r !== exp_r) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"MISMATCH @%0t: exp status=%0d slot=%0d refs=%0d, ",
                            "got status=%0d slot=%0d refs=%0d"},
                           $realtime, exp_r.status, exp_r.slot_index, exp_r.ref_count,
                           got_r.status, got_r.slot_index, got_r.ref_count);
            end
         end
      end
   end

   // watchdog: cycles with no transaction on either side
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_LIMIT) begin
         $display("TIMEOUT: no transaction for %0d cycles", WDOG_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      req_chan.valid    = 1'b0;
      req_chan.req_type = REQ_ACQUIRE;
      req_chan.name_key = '0;
      rsp_chan.ready    = 1'b0;
      no_idle           = 0;
      mismatches        = 0;
      errors            = 0;
      quiet_cycles      = 0;
      for (int i = 0; i < N_SLOTS; i++) begin
         tbl_busy[i]  = 1'b0;
         tbl_key[i]   = '0;
         tbl_count[i] = '0;
      end
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_hit_and_release();
      test_fill_to_full();
      test_random_traffic(8, 80);
      test_count_run();

      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (mismatches == 0 && errors == 0 && pending_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/refslot_pkg.sv
rtl/core/refslot_if.sv
rtl/core/refslot_ctrl.sv
rtl/core/refslot_dp.sv
rtl/core/refcounted_named_slot_table_core.sv
tb/tb_refcounted_named_slot_table_core.sv
